FILE: sv/mrsq_pkg.sv
// ----------------------------------------------------------------------------
// mrsq_pkg
// shared types, constants and the segment table of the isoline core
// ----------------------------------------------------------------------------
`default_nettype none

package mrsq_pkg;

   localparam int MaxLine    = 1024;
   localparam int SampleBits = 16;
   localparam int FracBits   = 8;
   localparam int AddrBits   = $clog2(MaxLine);
   localparam int CoordBits  = 30;
   localparam int DivBits    = 5 + SampleBits + FracBits;
   localparam int CntBits    = $clog2(DivBits);
   localparam int ProdBits   = CoordBits + 16;

   localparam logic [9:0] LineCountLimit = 10'd1023;

   // register indexes
   localparam logic [1:0] REG_LEVEL     = 2'd0;
   localparam logic [1:0] REG_CELL_SIZE = 2'd1;
   localparam logic [1:0] REG_SCALE     = 2'd2;

   // cell edges
   localparam logic [1:0] E_LEFT   = 2'd0;
   localparam logic [1:0] E_TOP    = 2'd1;
   localparam logic [1:0] E_RIGHT  = 2'd2;
   localparam logic [1:0] E_BOTTOM = 2'd3;

   typedef logic signed [SampleBits-1:0] sample_type;
   typedef logic [SampleBits-1:0]        mag_type;
   typedef logic [CoordBits-1:0]         coord_type;

   typedef struct packed {
      logic       start;
      logic [1:0] edge_sel;
      mag_type    a;
      mag_type    b;
      mag_type    c;
      mag_type    d;
      logic [9:0] x0;
      logic [9:0] y0;
   } pt_req_type;

   typedef struct packed {
      logic      done;
      coord_type px;
      coord_type py;
   } pt_rsp_type;

   function automatic mag_type magnitude(input logic [SampleBits-1:0] s);
      mag_type m;
      m = s[SampleBits-1] ? mag_type'(~s + 1'b1) : s;
      return m;
   endfunction

   function automatic logic [1:0] seg_count(input logic [3:0] code);
      logic [1:0] n;
      case (code)
         4'd0, 4'd15: n = 2'd0;
         4'd5, 4'd10: n = 2'd2;
         default:     n = 2'd1;
      endcase
      return n;
   endfunction

   // edge of segment k, side 0 start and side 1 end
   function automatic logic [1:0] seg_edge(input logic [3:0] code, input logic k,
                                           input logic side);
      logic [1:0] e;
      unique case (code)
         4'd1, 4'd14: e = side ? E_TOP : E_LEFT;
         4'd2, 4'd13: e = side ? E_RIGHT : E_TOP;
         4'd3, 4'd12: e = side ? E_RIGHT : E_LEFT;
         4'd4, 4'd11: e = side ? E_BOTTOM : E_RIGHT;
         4'd6, 4'd9:  e = side ? E_BOTTOM : E_TOP;
         4'd7, 4'd8:  e = side ? E_BOTTOM : E_LEFT;
         4'd5:        e = k ? (side ? E_RIGHT : E_TOP) : (side ? E_BOTTOM : E_LEFT);
         4'd10:       e = k ? (side ? E_BOTTOM : E_RIGHT) : (side ? E_TOP : E_LEFT);
         default:     e = E_LEFT;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

FILE: sv/mrsq_if.sv
// ----------------------------------------------------------------------------
// mrsq channel interfaces
// request, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface mrsq_req_if;
   logic                     valid;
   logic                     ready;
   mrsq_pkg::sample_type     sample;
   logic                     line_end;
   logic                     frame_start;
   modport source (output valid, sample, line_end, frame_start, input ready);
   modport sink   (input valid, sample, line_end, frame_start, output ready);
endinterface

interface mrsq_rsp_if;
   logic                 valid;
   logic                 ready;
   mrsq_pkg::coord_type  x_start;
   mrsq_pkg::coord_type  y_start;
   mrsq_pkg::coord_type  x_end;
   mrsq_pkg::coord_type  y_end;
   logic [3:0]           corner_code;
   logic                 last_of_cell;
   modport source (output valid, x_start, y_start, x_end, y_end, corner_code,
                   last_of_cell, input ready);
   modport sink   (input valid, x_start, y_start, x_end, y_end, corner_code,
                   last_of_cell, output ready);
endinterface

interface mrsq_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/mrsq_ram.sv
// ----------------------------------------------------------------------------
// mrsq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mrsq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/mrsq_point.sv
// ----------------------------------------------------------------------------
// mrsq_point
// one segment endpoint: edge interpolation by restoring division, then scale
// ----------------------------------------------------------------------------
`default_nettype none

module mrsq_point (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mrsq_pkg::pt_req_type pt_req,
   input  wire logic [14:0]          level,
   input  wire logic [4:0]           cell_size,
   input  wire logic [15:0]          scale_q8,
   output mrsq_pkg::pt_rsp_type      pt_rsp
);
   import mrsq_pkg::*;

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_DIV  = 3'd1;
   localparam logic [2:0] P_CRD  = 3'd2;
   localparam logic [2:0] P_MULX = 3'd3;
   localparam logic [2:0] P_MULY = 3'd4;
   localparam logic [2:0] P_DONE = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [DivBits-1:0]  quo_ff;
   mag_type             rem_ff;
   mag_type             den_ff;
   logic                dz_ff;
   logic [CntBits-1:0]  cnt_ff;
   logic [1:0]          eg_ff;
   logic [22:0]         bx_ff, by_ff;
   logic [12:0]         full_ff;
   coord_type           cx_ff, cy_ff, px_ff, py_ff;

   mag_type             vp, vq, lvl, num, den;
   logic [SampleBits:0] trial;
   logic                qbit;
   logic [DivBits-1:0]  off;
   coord_type           mul_a;
   logic [ProdBits-1:0] prod;
   logic [ProdBits-9:0] shifted;
   coord_type           sat;

   always_comb begin
      lvl = mag_type'(level);
      unique case (pt_req.edge_sel)
         E_LEFT:  begin vp = pt_req.d; vq = pt_req.a; end
         E_TOP:   begin vp = pt_req.a; vq = pt_req.b; end
         E_RIGHT: begin vp = pt_req.c; vq = pt_req.b; end
         default: begin vp = pt_req.d; vq = pt_req.c; end
      endcase
      if (vp <= lvl) begin
         num = lvl - vp;
         den = (vq > vp) ? vq - vp : '0;
      end else begin
         num = vp - lvl;
         den = (vp > vq) ? vp - vq : '0;
      end
   end

   always_comb begin
      trial = {rem_ff, quo_ff[DivBits-1]};
      qbit  = trial >= {1'b0, den_ff};
      off   = dz_ff ? '0 : quo_ff;
      mul_a = (state_ff == P_MULX) ? cx_ff : cy_ff;
      prod  = mul_a * scale_q8;
      shifted = prod[ProdBits-1:8];
      sat   = (shifted[ProdBits-9:CoordBits] != '0) ? '1 : shifted[CoordBits-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         P_IDLE: if (pt_req.start) state_in = P_DIV;
         P_DIV:  if (cnt_ff == '0) state_in = P_CRD;
         P_CRD:  state_in = P_MULX;
         P_MULX: state_in = P_MULY;
         P_MULY: state_in = P_DONE;
         P_DONE: state_in = P_IDLE;
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         P_IDLE: begin
            if (pt_req.start) begin
               quo_ff  <= {(DivBits-FracBits)'(num) * (DivBits-FracBits)'(cell_size),
                           FracBits'(0)};
               rem_ff  <= '0;
               den_ff  <= den;
               dz_ff   <= den == '0;
               cnt_ff  <= CntBits'(DivBits - 1);
               eg_ff   <= pt_req.edge_sel;
               bx_ff   <= {15'(pt_req.x0) * 15'(cell_size), FracBits'(0)};
               by_ff   <= {15'(pt_req.y0) * 15'(cell_size), FracBits'(0)};
               full_ff <= {cell_size, FracBits'(0)};
            end
         end
         P_DIV: begin
            rem_ff <= qbit ? mag_type'(trial - {1'b0, den_ff}) : trial[SampleBits-1:0];
            quo_ff <= {quo_ff[DivBits-2:0], qbit};
            cnt_ff <= cnt_ff - 1'b1;
         end
         P_CRD: begin
            unique case (eg_ff)
               E_LEFT: begin
                  cx_ff <= coord_type'(bx_ff);
                  cy_ff <= coord_type'(by_ff) + coord_type'(off);
               end
               E_TOP: begin
                  cx_ff <= coord_type'(bx_ff) + coord_type'(off);
                  cy_ff <= coord_type'(by_ff) + coord_type'(full_ff);
               end
               E_RIGHT: begin
                  cx_ff <= coord_type'(bx_ff) + coord_type'(full_ff);
                  cy_ff <= coord_type'(by_ff) + coord_type'(off);
               end
               default: begin
                  cx_ff <= coord_type'(bx_ff) + coord_type'(off);
                  cy_ff <= coord_type'(by_ff);
               end
            endcase
         end
         P_MULX: px_ff <= sat;
         P_MULY: py_ff <= sat;
         default: ;
      endcase
   end

   assign pt_rsp.done = state_ff == P_DONE;
   assign pt_rsp.px   = px_ff;
   assign pt_rsp.py   = py_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      pt_req.start |-> state_ff == P_IDLE)
      else $error("point start while busy");
   a_div_to_crd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == P_DIV && cnt_ff == '0) |=> state_ff == P_CRD)
      else $error("division did not finish");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      pt_rsp.done |=> !pt_rsp.done)
      else $error("done longer than one cycle");
`endif

endmodule

`default_nettype wire

FILE: sv/marching_squares_isoline_core.sv
// ----------------------------------------------------------------------------
// marching_squares_isoline_core
// streamed marching-squares isoline extraction with linear interpolation
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  req_ch   in   sample, line_end, frame_start
//  rsp_ch   out  x_start, y_start, x_end, y_end, corner_code, last_of_cell
//  csr_ch   in   index (0 level, 1 cell_size, 2 scale_q8), data
//
//  one request at a time; a sample past the line limit skips the line buffer,
//  otherwise each endpoint runs a 29-step restoring divider plus
//  coordinate and two scale multiplies, then 1 output load per segment,
//  up to 4 endpoints per cell
//  the line buffer read and write share one request slot, no overlap
//  a segment waits in the output register while rsp_ch stalls
//  synchronous reset, line buffer contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_isoline_core (
   input  wire logic clock,
   input  wire logic reset,
   mrsq_req_if.sink   req_ch,
   mrsq_rsp_if.source rsp_ch,
   mrsq_csr_if.sink   csr_ch
);
   import mrsq_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_GO   = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [14:0]         level_ff;
   logic [4:0]          cell_size_ff;
   logic [15:0]         scale_ff;
   logic [AddrBits:0]   pos_ff;
   logic [9:0]          lc_ff;
   logic [SampleBits-1:0] left_ff, left_above_ff, raw_ff;
   logic                le_ff;
   logic [AddrBits-1:0] x_ff;
   logic [9:0]          x0_ff, y0_ff;
   mag_type             a_ff, b_ff, c_ff, d_ff;
   logic [3:0]          code_ff;
   logic                k_ff, side_ff;
   coord_type           xs_ff, ys_ff;
   logic                rsp_valid_ff;
   coord_type           rsp_xs_ff, rsp_ys_ff, rsp_xe_ff, rsp_ye_ff;
   logic [3:0]          rsp_code_ff;
   logic                rsp_last_ff;

   logic [SampleBits-1:0] rd_data;
   logic                req_fire, rd_en, wr_en, out_load, is_last;
   logic [AddrBits:0]   pos_eff;
   logic [9:0]          lc_eff, lc_inc;
   mag_type             ma, mb, mc, md;
   logic [3:0]          code;
   pt_req_type          pt_req;
   pt_rsp_type          pt_rsp;

   assign req_ch.ready = state_ff == S_IDLE;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      pos_eff = req_ch.frame_start ? '0 : pos_ff;
      lc_eff  = req_ch.frame_start ? '0 : lc_ff;
      lc_inc  = (lc_eff < LineCountLimit) ? lc_eff + 1'b1 : lc_eff;
      rd_en   = req_fire && !pos_eff[AddrBits];
      wr_en   = state_ff == S_READ;
      ma = magnitude(left_ff);
      mb = magnitude(raw_ff);
      mc = magnitude(rd_data);
      md = magnitude(left_above_ff);
      code = {md > mag_type'(level_ff), mc > mag_type'(level_ff),
              mb > mag_type'(level_ff), ma > mag_type'(level_ff)};
      is_last  = (seg_count(code_ff) == 2'd1) || k_ff;
      out_load = state_ff == S_OUT && (!rsp_valid_ff || rsp_ch.ready);
   end

   always_comb begin
      pt_req.start    = state_ff == S_GO;
      pt_req.edge_sel = seg_edge(code_ff, k_ff, side_ff);
      pt_req.a  = a_ff;
      pt_req.b  = b_ff;
      pt_req.c  = c_ff;
      pt_req.d  = d_ff;
      pt_req.x0 = x0_ff;
      pt_req.y0 = y0_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (rd_en) state_in = S_READ;
         S_READ: begin
            if (x_ff != '0 && lc_ff != '0 && seg_count(code) != 2'd0) begin
               state_in = S_GO;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_GO:   state_in = S_WAIT;
         S_WAIT: if (pt_rsp.done) state_in = side_ff ? S_OUT : S_GO;
         S_OUT:  if (out_load) state_in = is_last ? S_IDLE : S_GO;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         cell_size_ff <= 5'd2;
         scale_ff     <= 16'd256;
         pos_ff       <= '0;
         lc_ff        <= '0;
         left_ff      <= '0;
         left_above_ff <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= 1'b0;
         side_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               REG_LEVEL:     level_ff     <= csr_ch.data[14:0];
               REG_CELL_SIZE: cell_size_ff <= csr_ch.data[4:0];
               REG_SCALE:     scale_ff     <= csr_ch.data;
               default: ;
            endcase
         end
         if (req_fire) begin
            // overflowed line: only line_end matters
            if (pos_eff[AddrBits] && req_ch.line_end) begin
               pos_ff <= '0;
               lc_ff  <= lc_inc;
            end else begin
               pos_ff <= pos_eff;
               lc_ff  <= lc_eff;
            end
         end
         if (state_ff == S_READ) begin
            left_above_ff <= rd_data;
            left_ff       <= raw_ff;
            k_ff          <= 1'b0;
            side_ff       <= 1'b0;
            if (le_ff) begin
               pos_ff <= '0;
               lc_ff  <= (lc_ff < LineCountLimit) ? lc_ff + 1'b1 : lc_ff;
            end else begin
               pos_ff <= {1'b0, x_ff} + 1'b1;
            end
         end
         if (state_ff == S_WAIT && pt_rsp.done) begin
            side_ff <= !side_ff;
         end
         if (out_load && !is_last) begin
            k_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         raw_ff <= req_ch.sample;
         le_ff  <= req_ch.line_end;
         x_ff   <= pos_eff[AddrBits-1:0];
      end
      if (state_ff == S_READ) begin
         a_ff    <= ma;
         b_ff    <= mb;
         c_ff    <= mc;
         d_ff    <= md;
         code_ff <= code;
         x0_ff   <= 10'(x_ff - 1'b1);
         y0_ff   <= lc_ff - 1'b1;
      end
      if (state_ff == S_WAIT && pt_rsp.done && !side_ff) begin
         xs_ff <= pt_rsp.px;
         ys_ff <= pt_rsp.py;
      end
      if (out_load) begin
         rsp_xs_ff   <= xs_ff;
         rsp_ys_ff   <= ys_ff;
         rsp_xe_ff   <= pt_rsp.px;
         rsp_ye_ff   <= pt_rsp.py;
         rsp_code_ff <= code_ff;
         rsp_last_ff <= is_last;
      end
   end

   mrsq_ram #(
      .WIDTH (SampleBits),
      .DEPTH (MaxLine)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (x_ff),
      .wr_data (raw_ff),
      .rd_en   (rd_en),
      .rd_addr (pos_eff[AddrBits-1:0]),
      .rd_data (rd_data)
   );

   mrsq_point u_point (
      .clock     (clock),
      .reset     (reset),
      .pt_req    (pt_req),
      .level     (level_ff),
      .cell_size (cell_size_ff),
      .scale_q8  (scale_ff),
      .pt_rsp    (pt_rsp)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.x_start      = rsp_xs_ff;
   assign rsp_ch.y_start      = rsp_ys_ff;
   assign rsp_ch.x_end        = rsp_xe_ff;
   assign rsp_ch.y_end        = rsp_ye_ff;
   assign rsp_ch.corner_code  = rsp_code_ff;
   assign rsp_ch.last_of_cell = rsp_last_ff;

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= (AddrBits+1)'(MaxLine))
      else $error("position beyond line limit");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(rsp_xe_ff) && rsp_valid_ff)
      else $error("pending segment overwritten");
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> wr_en)
      else $error("line buffer not written back");
   a_code_has_segs: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GO |-> seg_count(code_ff) != 2'd0)
      else $error("endpoint for empty cell");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for marching_squares_isoline_core: streams grids of
// signed samples under several register settings, predicts every segment
// and compares each one as it leaves the core
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import mrsq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 1500000;
   localparam int DrainWait  = 200;

   typedef struct {
      coord_type  x_start;
      coord_type  y_start;
      coord_type  x_end;
      coord_type  y_end;
      logic [3:0] corner_code;
      logic       last_of_cell;
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrsq_req_if req_ch ();
   mrsq_rsp_if rsp_ch ();
   mrsq_csr_if csr_ch ();

   marching_squares_isoline_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [14:0]  iso_level;
   logic [4:0]   iso_cell;
   logic [15:0]  iso_scale;
   logic [15:0]  row_mem [MaxLine];
   logic [15:0]  left_val, left_above_val;
   int unsigned  cur_row, cur_col;
   int unsigned  stored_len;

   segment_type  segments_due[$];
   int           errors = 0;
   int           requests_sent = 0;
   int           segments_seen = 0;
   int           cycles = 0;
   logic [15:0]  codes_seen = '0;

   // sender pacing and receiver hold-off
   int           burst_left = 0;
   bit           hold_request = 1'b0;

   function automatic longint unsigned mag_of(logic [15:0] s);
      return s[15] ? 65536 - longint'(s) : longint'(s);
   endfunction

   function automatic longint unsigned cross_offset(longint unsigned vp,
                                                    longint unsigned vq);
      longint unsigned t, num, den;
      t = iso_level;
      if (vp <= t) begin
         num = t - vp;
         den = (vq > vp) ? vq - vp : 0;
      end else begin
         num = vp - t;
         den = (vp > vq) ? vp - vq : 0;
      end
      if (den == 0) return 0;
      return ((longint'(iso_cell) * num) << FracBits) / den;
   endfunction

   function automatic coord_type scaled(longint unsigned v);
      longint unsigned r;
      r = (v * iso_scale) >> 8;
      return (r > 64'h3FFF_FFFF) ? coord_type'(30'h3FFF_FFFF) : coord_type'(r);
   endfunction

   task automatic edge_point(input logic [1:0] e, input longint unsigned x0, y0,
                             input longint unsigned a, b, c, d,
                             output coord_type px, output coord_type py);
      longint unsigned bx, by, full, x, y;
      bx = (x0 * iso_cell) << FracBits;
      by = (y0 * iso_cell) << FracBits;
      full = longint'(iso_cell) << FracBits;
      case (e)
         E_LEFT: begin
            x = bx; y = by + cross_offset(d, a);
         end
         E_TOP: begin
            x = bx + cross_offset(a, b); y = by + full;
         end
         E_RIGHT: begin
            x = bx + full; y = by + cross_offset(c, b);
         end
         default: begin
            x = bx + cross_offset(d, c); y = by;
         end
      endcase
      px = scaled(x);
      py = scaled(y);
   endtask

   // start and end edge of segment k for a corner code
   task automatic cell_edges(input logic [3:0] code, input int k,
                             output logic [1:0] es, output logic [1:0] ee);
      case (code)
         4'd1, 4'd14: begin es = E_LEFT;  ee = E_TOP;    end
         4'd2, 4'd13: begin es = E_TOP;   ee = E_RIGHT;  end
         4'd3, 4'd12: begin es = E_LEFT;  ee = E_RIGHT;  end
         4'd4, 4'd11: begin es = E_RIGHT; ee = E_BOTTOM; end
         4'd6, 4'd9:  begin es = E_TOP;   ee = E_BOTTOM; end
         4'd7, 4'd8:  begin es = E_LEFT;  ee = E_BOTTOM; end
         4'd5: begin
            es = k ? E_TOP : E_LEFT;
            ee = k ? E_RIGHT : E_BOTTOM;
         end
         default: begin
            es = k ? E_RIGHT : E_LEFT;
            ee = k ? E_BOTTOM : E_TOP;
         end
      endcase
   endtask

   task automatic predict_cell(input logic [15:0] s, input logic le, input logic fs);
      longint unsigned a, b, c, d, t;
      logic [15:0]     above;
      logic [3:0]      code;
      logic [1:0]      es, ee;
      int              cnt;
      segment_type     seg;
      if (fs) begin
         cur_col = 0;
         cur_row = 0;
      end
      if (cur_col < MaxLine) begin
         above = row_mem[cur_col];
         if (cur_col >= 1 && cur_row >= 1) begin
            a = mag_of(left_val);
            b = mag_of(s);
            c = mag_of(above);
            d = mag_of(left_above_val);
            t = iso_level;
            code = {d > t, c > t, b > t, a > t};
            codes_seen[code] = 1'b1;
            cnt = (code == 4'd0 || code == 4'd15) ? 0 :
                  (code == 4'd5 || code == 4'd10) ? 2 : 1;
            for (int k = 0; k < cnt; k++) begin
               cell_edges(code, k, es, ee);
               edge_point(es, cur_col - 1, cur_row - 1, a, b, c, d,
                          seg.x_start, seg.y_start);
               edge_point(ee, cur_col - 1, cur_row - 1, a, b, c, d,
                          seg.x_end, seg.y_end);
               seg.corner_code = code;
               seg.last_of_cell = (k == cnt - 1);
               segments_due.push_back(seg);
            end
         end
         left_above_val = above;
         left_val = s;
         row_mem[cur_col] = s;
         cur_col++;
         if (cur_col > stored_len) stored_len = cur_col;
      end
      if (le) begin
         cur_col = 0;
         if (cur_row < LineCountLimit) cur_row++;
      end
   endtask

   // one request, with bursts and gaps on the sending side
   task automatic send_sample(input logic [15:0] s, input logic le, input logic fs);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.sample <= s;
      req_ch.line_end <= le;
      req_ch.frame_start <= fs;
      do @(posedge clock); while (!req_ch.ready);
      predict_cell(s, le, fs);
      requests_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (segments_due.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_LEVEL:     iso_level = value[14:0];
         REG_CELL_SIZE: iso_cell = value[4:0];
         default:       iso_scale = value;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [15:0] lvl, input logic [15:0] cs,
                           input logic [15:0] sc);
      wait_idle();
      write_reg(REG_LEVEL, lvl);
      write_reg(REG_CELL_SIZE, cs);
      write_reg(REG_SCALE, sc);
   endtask

   // value close to the level most of the time so edges get crossed
   function automatic logic [15:0] pick_sample();
      int v;
      if ($urandom_range(0, 9) < 4) return 16'($urandom());
      v = int'(iso_level) + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > 32768) v = 32768;
      return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
   endfunction

   task automatic test_directed();
      set_regs(16'd100, 16'd2, 16'd256);
      send_sample(-16'sd32768, 1'b0, 1'b1);
      send_sample(16'sd32767, 1'b0, 1'b0);
      send_sample(16'sd0, 1'b0, 1'b0);
      send_sample(16'sd101, 1'b0, 1'b0);
      send_sample(-16'sd101, 1'b1, 1'b0);
      send_sample(16'sd0, 1'b0, 1'b0);
      send_sample(-16'sd32768, 1'b0, 1'b0);
      send_sample(16'sd100, 1'b0, 1'b0);
      send_sample(-16'sd100, 1'b0, 1'b0);
      send_sample(16'sd32767, 1'b1, 1'b0);
      send_sample(16'sd200, 1'b0, 1'b0);
      send_sample(-16'sd5, 1'b0, 1'b0);
      send_sample(-16'sd32767, 1'b0, 1'b0);
      send_sample(16'sd150, 1'b0, 1'b0);
      send_sample(16'sd3, 1'b1, 1'b0);
      // checkerboard gives both saddles
      send_sample(16'sd0, 1'b0, 1'b1);
      send_sample(16'sd500, 1'b0, 1'b0);
      send_sample(-16'sd1, 1'b1, 1'b0);
      send_sample(-16'sd500, 1'b0, 1'b0);
      send_sample(16'sd2, 1'b0, 1'b0);
      send_sample(16'sd999, 1'b1, 1'b0);
      // one-sample line that also starts a frame
      send_sample(16'sd7, 1'b1, 1'b1);
   endtask

   task automatic run_frames(input int count);
      int len, sent;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(2, 14);
         if ($urandom_range(0, 19) == 0) len = $urandom_range(20, 48);
         for (int y = 0; y < $urandom_range(2, 8) && sent < count; y++) begin
            if (y > 0) len = $urandom_range(1, stored_len < len ? stored_len : len);
            for (int x = 0; x < len; x++) begin
               // occasional broken framing
               if (x > 0 && $urandom_range(0, 39) == 0) begin
                  send_sample(pick_sample(), 1'b0, 1'b1);
                  len = x + 1;
               end else
                  send_sample(pick_sample(), x == len - 1 || $urandom_range(0, 49) == 0,
                              x == 0 && y == 0);
               sent++;
               if (cur_col == 0) break;
            end
            if (cur_col != 0) send_sample(pick_sample(), 1'b1, 1'b0);
         end
      end
   endtask

   task automatic test_random();
      set_regs(16'd100, 16'd2, 16'd256);
      run_frames(90);
      set_regs(16'd0, 16'd1, 16'd1);
      run_frames(90);
      set_regs(16'd32767, 16'd16, 16'd65535);
      run_frames(90);
      set_regs(16'd1000, 16'd0, 16'd512);
      hold_request = 1'b1;
      run_frames(90);
      set_regs(16'($urandom_range(0, 32767)), 16'd31, 16'($urandom_range(1, 65535)));
      run_frames(90);
      set_regs(16'($urandom_range(0, 4000)), 16'($urandom_range(1, 16)),
               16'($urandom_range(1, 65535)));
      run_frames(90);
   endtask

   // receiver: ready pattern switches between always ready, random and sparse modes
   initial begin
      int mode_cycles, mode, hold;
      mode_cycles = 0;
      mode = 0;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && hold == 0) begin
            hold = 600;
            hold_request = 1'b0;
         end
         if (mode_cycles == 0) begin
            mode = $urandom_range(0, 2);
            mode_cycles = $urandom_range(100, 400);
         end
         mode_cycles--;
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= $urandom_range(0, 1);
            default: rsp_ch.ready <= (mode_cycles % 5 == 0);
         endcase
      end
   end

   // compare each segment with the oldest one predicted
   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         segments_seen++;
         if (segments_due.size() == 0) begin
            $error("segment with none expected: code %0d", rsp_ch.corner_code);
            errors++;
         end else begin
            want = segments_due.pop_front();
            if (rsp_ch.x_start !== want.x_start) begin
               $error("x_start expected %0d got %0d", want.x_start, rsp_ch.x_start);
               errors++;
            end
            if (rsp_ch.y_start !== want.y_start) begin
               $error("y_start expected %0d got %0d", want.y_start, rsp_ch.y_start);
               errors++;
            end
            if (rsp_ch.x_end !== want.x_end) begin
               $error("x_end expected %0d got %0d", want.x_end, rsp_ch.x_end);
               errors++;
            end
            if (rsp_ch.y_end !== want.y_end) begin
               $error("y_end expected %0d got %0d", want.y_end, rsp_ch.y_end);
               errors++;
            end
            if (rsp_ch.corner_code !== want.corner_code) begin
               $error("corner_code expected %0d got %0d", want.corner_code,
                      rsp_ch.corner_code);
               errors++;
            end
            if (rsp_ch.last_of_cell !== want.last_of_cell) begin
               $error("last_of_cell expected %0d got %0d", want.last_of_cell,
                      rsp_ch.last_of_cell);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d segments outstanding", cycles,
                  segments_due.size());
         $display("FAIL marching_squares_isoline_core");
         $finish;
      end
   end

   initial begin
      iso_level = '0;
      iso_cell = 5'd2;
      iso_scale = 16'd256;
      left_val = '0;
      left_above_val = '0;
      cur_row = 0;
      cur_col = 0;
      stored_len = 0;
      foreach (row_mem[i]) row_mem[i] = '0;
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      req_ch.line_end = 1'b0;
      req_ch.frame_start = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_LEVEL;
      csr_ch.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random();
      wait_idle();

      $display("%0d requests, %0d segments checked, corner codes hit mask %b",
               requests_sent, segments_seen, codes_seen);
      $display("covered saddles, broken framing, a long output stall and six settings");
      if (errors == 0)
         $display("PASS marching_squares_isoline_core");
      else
         $display("FAIL marching_squares_isoline_core");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
sv/mrsq_pkg.sv
sv/mrsq_if.sv
sv/mrsq_ram.sv
sv/mrsq_point.sv
sv/marching_squares_isoline_core.sv
tb/tb_top.sv
